// File: hdl/jsu8_pkg.sv
// Shared types, constants and helpers for the JSON string unescaper.
// Used by json_string_unescape_utf8_core; no dependencies.
`default_nettype none

package jsu8_pkg;

    // decoder phase codes
    localparam logic [3:0] PH_PLAIN   = 4'd0;
    localparam logic [3:0] PH_ESC     = 4'd1;
    localparam logic [3:0] PH_QUAD_A  = 4'd2;
    localparam logic [3:0] PH_WANT_BS = 4'd6;
    localparam logic [3:0] PH_WANT_U  = 4'd7;
    localparam logic [3:0] PH_QUAD_B  = 4'd8;
    localparam logic [3:0] PH_DONE_B  = 4'd12;

    // characters of interest
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_BSL   = 8'h5C;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_B     = 8'h62;
    localparam logic [7:0] CH_F     = 8'h66;
    localparam logic [7:0] CH_N     = 8'h6E;
    localparam logic [7:0] CH_R     = 8'h72;
    localparam logic [7:0] CH_T     = 8'h74;
    localparam logic [7:0] CH_U     = 8'h75;
    localparam logic [7:0] CH_SPACE = 8'h20;

    localparam logic [7:0] BS_CODE  = 8'h08;
    localparam logic [7:0] FF_CODE  = 8'h0C;
    localparam logic [7:0] LF_CODE  = 8'h0A;
    localparam logic [7:0] CR_CODE  = 8'h0D;
    localparam logic [7:0] TAB_CODE = 8'h09;

    localparam logic [15:0] HI_SURR_MIN = 16'hD800;
    localparam logic [15:0] HI_SURR_MAX = 16'hDBFF;
    localparam logic [15:0] LO_SURR_MIN = 16'hDC00;
    localparam logic [15:0] LO_SURR_MAX = 16'hDFFF;
    localparam logic [20:0] SUPP_BASE   = 21'h10000;
    localparam logic [20:0] CP_MAX1     = 21'h7F;
    localparam logic [20:0] CP_MAX2     = 21'h7FF;
    localparam logic [20:0] CP_MAX3     = 21'hFFFF;

    localparam logic [7:0] LEAD2 = 8'hC0;
    localparam logic [7:0] LEAD3 = 8'hE0;
    localparam logic [7:0] LEAD4 = 8'hF0;
    localparam logic [7:0] CONT  = 8'h80;

    typedef struct packed {
        logic [3:0][7:0] bytes;   // bytes[0] goes out first
        logic [2:0]      cnt;
    } utf8_t;

    typedef struct packed {
        logic       ok;
        logic [3:0] val;
    } hex_t;

    function automatic hex_t hex_decode(input logic [7:0] c);
        hex_t r;
        r.ok  = 1'b1;
        r.val = 4'd0;
        case (c) inside
            [8'h30:8'h39]: r.val = 4'(c - 8'h30);
            [8'h61:8'h66]: r.val = 4'(c - 8'h57);
            [8'h41:8'h46]: r.val = 4'(c - 8'h37);
            default:       r.ok  = 1'b0;
        endcase
        return r;
    endfunction

    function automatic utf8_t utf8_encode(input logic [20:0] cp);
        utf8_t r;
        r.bytes = '0;
        if (cp <= CP_MAX1) begin
            r.cnt      = 3'd1;
            r.bytes[0] = cp[7:0];
        end
        else if (cp <= CP_MAX2) begin
            r.cnt      = 3'd2;
            r.bytes[0] = LEAD2 | {3'b000, cp[10:6]};
            r.bytes[1] = CONT | {2'b00, cp[5:0]};
        end
        else if (cp <= CP_MAX3) begin
            r.cnt      = 3'd3;
            r.bytes[0] = LEAD3 | {4'b0000, cp[15:12]};
            r.bytes[1] = CONT | {2'b00, cp[11:6]};
            r.bytes[2] = CONT | {2'b00, cp[5:0]};
        end
        else begin
            r.cnt      = 3'd4;
            r.bytes[0] = LEAD4 | {5'b00000, cp[20:18]};
            r.bytes[1] = CONT | {2'b00, cp[17:12]};
            r.bytes[2] = CONT | {2'b00, cp[11:6]};
            r.bytes[3] = CONT | {2'b00, cp[5:0]};
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// File: hdl/json_string_unescape_utf8_core.sv
// JSON string body unescaper on jsu8_pkg: string bytes in, UTF-8 and status words out.
// A byte enters the input register and is decoded into the result bundle register.
// Throughput one input byte per cycle while out_stall is low and each byte yields
// at most one word; a byte with more words (up to 4 UTF-8 bytes plus status) holds the
// output register until its last word is taken; the input register stalls behind it.
// Reset (rst_n, async, active low) empties both registers and clears the decoder.
`default_nettype none

module json_string_unescape_utf8_core (
    input  wire logic       clk,
    input  wire logic       rst_n,
    // input channel
    input  wire logic       in_valid,
    output logic            in_stall,
    input  wire logic [7:0] in_byte,
    input  wire logic       last,
    // output channel
    output logic            out_valid,
    input  wire logic       out_stall,
    output logic [7:0]      out_byte,
    output logic            has_byte,
    output logic            end_of_string,
    output logic            bad_string
);

    // input register
    logic       in_v_reg;
    logic [7:0] in_byte_reg;
    logic       in_last_reg;

    // decoder state
    logic [3:0]  phase_reg,  phase_next;
    logic [15:0] acc_reg,    acc_next;
    logic [9:0]  hs_reg,     hs_next;
    logic        err_reg,    err_next;

    // result bundle register
    logic [3:0][7:0] bytes_reg;
    logic [2:0]      nbytes_reg;
    logic            eos_reg;
    logic            bad_reg;

    // decode outputs
    jsu8_pkg::utf8_t emit;
    logic            status_bad;
    jsu8_pkg::hex_t  hx;
    logic [15:0]     acc_new;
    logic [3:0]      phase_inc;
    logic            fail;

    logic out_take, last_take, bund_free, move, in_take;

    assign out_valid = (nbytes_reg != 3'd0) || eos_reg;
    assign out_take  = out_valid && !out_stall;
    assign last_take = (nbytes_reg == 3'd0) || (nbytes_reg == 3'd1 && !eos_reg);
    assign bund_free = !out_valid || (out_take && last_take);
    assign move      = in_v_reg && bund_free;
    assign in_stall  = in_v_reg && !bund_free;
    assign in_take   = in_valid && !in_stall;

    assign has_byte      = (nbytes_reg != 3'd0);
    assign out_byte      = has_byte ? bytes_reg[0] : 8'h00;
    assign end_of_string = !has_byte && eos_reg;
    assign bad_string    = end_of_string && bad_reg;

    assign hx        = jsu8_pkg::hex_decode(in_byte_reg);
    assign acc_new   = {acc_reg[11:0], hx.val};
    assign phase_inc = 4'(phase_reg + 4'd1);

    always_comb
    begin
        phase_next = phase_reg;
        acc_next   = acc_reg;
        hs_next    = hs_reg;
        err_next   = err_reg;
        emit       = '0;
        fail       = 1'b0;
        if (!err_reg)
        begin
            case (phase_reg) inside
                jsu8_pkg::PH_PLAIN:
                begin
                    if (in_byte_reg < jsu8_pkg::CH_SPACE)
                        fail = 1'b1;
                    else if (in_byte_reg == jsu8_pkg::CH_BSL)
                        phase_next = jsu8_pkg::PH_ESC;
                    else
                    begin
                        emit.cnt      = 3'd1;
                        emit.bytes[0] = in_byte_reg;
                    end
                end
                jsu8_pkg::PH_ESC:
                begin
                    phase_next = jsu8_pkg::PH_PLAIN;
                    emit.cnt   = 3'd1;
                    case (in_byte_reg)
                        jsu8_pkg::CH_QUOTE,
                        jsu8_pkg::CH_BSL,
                        jsu8_pkg::CH_SLASH: emit.bytes[0] = in_byte_reg;
                        jsu8_pkg::CH_B:     emit.bytes[0] = jsu8_pkg::BS_CODE;
                        jsu8_pkg::CH_F:     emit.bytes[0] = jsu8_pkg::FF_CODE;
                        jsu8_pkg::CH_N:     emit.bytes[0] = jsu8_pkg::LF_CODE;
                        jsu8_pkg::CH_R:     emit.bytes[0] = jsu8_pkg::CR_CODE;
                        jsu8_pkg::CH_T:     emit.bytes[0] = jsu8_pkg::TAB_CODE;
                        jsu8_pkg::CH_U:
                        begin
                            emit.cnt   = 3'd0;
                            acc_next   = 16'h0000;
                            phase_next = jsu8_pkg::PH_QUAD_A;
                        end
                        default:
                        begin
                            emit.cnt = 3'd0;
                            fail     = 1'b1;
                        end
                    endcase
                end
                jsu8_pkg::PH_WANT_BS:
                begin
                    if (in_byte_reg == jsu8_pkg::CH_BSL)
                        phase_next = jsu8_pkg::PH_WANT_U;
                    else
                        fail = 1'b1;
                end
                jsu8_pkg::PH_WANT_U:
                begin
                    if (in_byte_reg == jsu8_pkg::CH_U)
                    begin
                        acc_next   = 16'h0000;
                        phase_next = jsu8_pkg::PH_QUAD_B;
                    end
                    else
                        fail = 1'b1;
                end
                [jsu8_pkg::PH_QUAD_A:jsu8_pkg::PH_WANT_BS - 4'd1],
                [jsu8_pkg::PH_QUAD_B:jsu8_pkg::PH_DONE_B - 4'd1]:
                begin
                    if (!hx.ok)
                        fail = 1'b1;
                    else
                    begin
                        acc_next   = acc_new;
                        phase_next = phase_inc;
                        if (phase_inc == jsu8_pkg::PH_WANT_BS)
                        begin
                            if (acc_new >= jsu8_pkg::HI_SURR_MIN &&
                                acc_new <= jsu8_pkg::HI_SURR_MAX)
                                hs_next = acc_new[9:0];
                            else if (acc_new >= jsu8_pkg::LO_SURR_MIN &&
                                     acc_new <= jsu8_pkg::LO_SURR_MAX)
                                fail = 1'b1;
                            else
                            begin
                                emit       = jsu8_pkg::utf8_encode({5'b00000, acc_new});
                                phase_next = jsu8_pkg::PH_PLAIN;
                            end
                        end
                        else if (phase_inc == jsu8_pkg::PH_DONE_B)
                        begin
                            if (acc_new >= jsu8_pkg::LO_SURR_MIN &&
                                acc_new <= jsu8_pkg::LO_SURR_MAX)
                            begin
                                emit = jsu8_pkg::utf8_encode(jsu8_pkg::SUPP_BASE +
                                           {1'b0, hs_reg, acc_new[9:0]});
                                phase_next = jsu8_pkg::PH_PLAIN;
                            end
                            else
                                fail = 1'b1;
                        end
                    end
                end
                default: fail = 1'b1;
            endcase
        end
        if (fail)
        begin
            err_next   = 1'b1;
            phase_next = jsu8_pkg::PH_PLAIN;
        end
        // unfinished escape at the final byte counts as malformed
        status_bad = err_next || (phase_next != jsu8_pkg::PH_PLAIN);
        if (in_last_reg)
        begin
            phase_next = jsu8_pkg::PH_PLAIN;
            acc_next   = 16'h0000;
            hs_next    = 10'd0;
            err_next   = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_v_reg   <= 1'b0;
            phase_reg  <= jsu8_pkg::PH_PLAIN;
            acc_reg    <= 16'h0000;
            hs_reg     <= 10'd0;
            err_reg    <= 1'b0;
            nbytes_reg <= 3'd0;
            eos_reg    <= 1'b0;
        end
        else
        begin
            if (in_take)
                in_v_reg <= 1'b1;
            else if (move)
                in_v_reg <= 1'b0;

            if (move)
            begin
                phase_reg  <= phase_next;
                acc_reg    <= acc_next;
                hs_reg     <= hs_next;
                err_reg    <= err_next;
                nbytes_reg <= emit.cnt;
                eos_reg    <= in_last_reg;
            end
            else if (out_take)
            begin
                if (nbytes_reg != 3'd0)
                    nbytes_reg <= 3'(nbytes_reg - 3'd1);
                else
                    eos_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_byte_reg <= in_byte;
            in_last_reg <= last;
        end
        if (move)
        begin
            bytes_reg <= emit.bytes;
            bad_reg   <= status_bad;
        end
        else if (out_take && nbytes_reg != 3'd0)
            bytes_reg <= bytes_reg >> 8;
    end

    // input side only stalls while the input register holds a word
    a_stall_needs_word: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> in_v_reg)
        else $error("input stalled with empty input register");

    // decoder is back at reset state after a final byte
    a_clean_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        move && in_last_reg |=> phase_reg == jsu8_pkg::PH_PLAIN && !err_reg)
        else $error("decoder state not cleared after end of string");

    // bytes after an error yield nothing until the final byte
    a_quiet_after_err: assert property (@(posedge clk) disable iff (!rst_n)
        move && err_reg && !in_last_reg |=> !out_valid)
        else $error("output produced after error");

    // at most four decoded bytes per word, and the quad counter stays in range
    a_bundle_bound: assert property (@(posedge clk) disable iff (!rst_n)
        nbytes_reg <= 3'd4 && phase_reg < jsu8_pkg::PH_DONE_B)
        else $error("result count or phase out of range");

endmodule

`default_nettype wire

// File: tb/tb_json_string_unescape_utf8_core.sv
// Testbench for json_string_unescape_utf8_core: drives JSON string bodies and checks every
// decoded UTF-8 word and status word against an in-bench decoder with random idle on both sides.
// Depends on jsu8_pkg and the core RTL only.
module tb_json_string_unescape_utf8_core;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int RANDOM_ITEMS = 270;
    localparam int TAIL_CYCLES  = 20;
    localparam logic [7:0] ESC_LETTERS [8] = '{jsu8_pkg::CH_QUOTE, jsu8_pkg::CH_BSL,
                                              jsu8_pkg::CH_SLASH, jsu8_pkg::CH_B,
                                              jsu8_pkg::CH_F, jsu8_pkg::CH_N,
                                              jsu8_pkg::CH_R, jsu8_pkg::CH_T};

    typedef struct packed {
        logic [7:0] data;
        logic       has;
        logic       eos;
        logic       bad;
    } word_t;

    class unescape_predictor;
        word_t      pending_words[$];
        int         errors;
        logic [3:0] phase;
        logic [15:0] quad;
        logic [9:0] hi_bits;
        logic       malformed;

        function new();
            errors = 0;
            clear();
        endfunction

        function void clear();
            phase     = jsu8_pkg::PH_PLAIN;
            quad      = '0;
            hi_bits   = '0;
            malformed = 1'b0;
        endfunction

        function int pending();
            return pending_words.size();
        endfunction

        function int nibble(logic [7:0] c);
            if (c >= 8'h30 && c <= 8'h39) return int'(c) - 'h30;
            if (c >= 8'h61 && c <= 8'h66) return int'(c) - 'h61 + 10;
            if (c >= 8'h41 && c <= 8'h46) return int'(c) - 'h41 + 10;
            return -1;
        endfunction

        function void emit(logic [7:0] b);
            word_t w;
            w = {b, 1'b1, 1'b0, 1'b0};
            pending_words.push_back(w);
        endfunction

        function void emit_cp(logic [20:0] cp);
            if (cp < 21'h80)
                emit(cp[7:0]);
            else if (cp < 21'h800)
            begin
                emit(jsu8_pkg::LEAD2 | 8'(cp >> 6));
                emit(jsu8_pkg::CONT | 8'(cp & 21'h3F));
            end
            else if (cp < 21'h10000)
            begin
                emit(jsu8_pkg::LEAD3 | 8'(cp >> 12));
                emit(jsu8_pkg::CONT | 8'((cp >> 6) & 21'h3F));
                emit(jsu8_pkg::CONT | 8'(cp & 21'h3F));
            end
            else
            begin
                emit(jsu8_pkg::LEAD4 | 8'((cp >> 18) & 21'h7));
                emit(jsu8_pkg::CONT | 8'((cp >> 12) & 21'h3F));
                emit(jsu8_pkg::CONT | 8'((cp >> 6) & 21'h3F));
                emit(jsu8_pkg::CONT | 8'(cp & 21'h3F));
            end
        endfunction

        function void set_error();
            malformed = 1'b1;
            phase     = jsu8_pkg::PH_PLAIN;
        endfunction

        function void decode(logic [7:0] b);
            int d;
            logic [15:0] acc;
            if (phase == jsu8_pkg::PH_PLAIN)
            begin
                if (b < jsu8_pkg::CH_SPACE) set_error();
                else if (b == jsu8_pkg::CH_BSL) phase = jsu8_pkg::PH_ESC;
                else emit(b);
            end
            else if (phase == jsu8_pkg::PH_ESC)
            begin
                phase = jsu8_pkg::PH_PLAIN;
                case (b)
                    jsu8_pkg::CH_QUOTE, jsu8_pkg::CH_BSL, jsu8_pkg::CH_SLASH: emit(b);
                    jsu8_pkg::CH_B: emit(jsu8_pkg::BS_CODE);
                    jsu8_pkg::CH_F: emit(jsu8_pkg::FF_CODE);
                    jsu8_pkg::CH_N: emit(jsu8_pkg::LF_CODE);
                    jsu8_pkg::CH_R: emit(jsu8_pkg::CR_CODE);
                    jsu8_pkg::CH_T: emit(jsu8_pkg::TAB_CODE);
                    jsu8_pkg::CH_U:
                    begin
                        quad  = '0;
                        phase = jsu8_pkg::PH_QUAD_A;
                    end
                    default: set_error();
                endcase
            end
            else if (phase == jsu8_pkg::PH_WANT_BS)
            begin
                if (b == jsu8_pkg::CH_BSL) phase = jsu8_pkg::PH_WANT_U;
                else set_error();
            end
            else if (phase == jsu8_pkg::PH_WANT_U)
            begin
                if (b == jsu8_pkg::CH_U)
                begin
                    quad  = '0;
                    phase = jsu8_pkg::PH_QUAD_B;
                end
                else
                    set_error();
            end
            else if (phase < jsu8_pkg::PH_DONE_B)
            begin
                d = nibble(b);
                if (d < 0)
                begin
                    set_error();
                    return;
                end
                acc   = {quad[11:0], 4'(d)};
                quad  = acc;
                phase = phase + 4'd1;
                if (phase == jsu8_pkg::PH_WANT_BS)
                begin
                    if (acc >= jsu8_pkg::HI_SURR_MIN && acc <= jsu8_pkg::HI_SURR_MAX)
                        hi_bits = 10'(acc - jsu8_pkg::HI_SURR_MIN);
                    else if (acc >= jsu8_pkg::LO_SURR_MIN && acc <= jsu8_pkg::LO_SURR_MAX)
                        set_error();
                    else
                    begin
                        emit_cp(21'(acc));
                        phase = jsu8_pkg::PH_PLAIN;
                    end
                end
                else if (phase == jsu8_pkg::PH_DONE_B)
                begin
                    if (acc >= jsu8_pkg::LO_SURR_MIN && acc <= jsu8_pkg::LO_SURR_MAX)
                    begin
                        emit_cp(jsu8_pkg::SUPP_BASE +
                                21'({hi_bits, 10'(acc - jsu8_pkg::LO_SURR_MIN)}));
                        phase = jsu8_pkg::PH_PLAIN;
                    end
                    else
                        set_error();
                end
            end
            else
                set_error();
        endfunction

        // one accepted input word
        function void take_input(logic [7:0] b, logic fin);
            word_t w;
            if (!malformed) decode(b);
            if (fin)
            begin
                if (!malformed && phase != jsu8_pkg::PH_PLAIN) malformed = 1'b1;
                w = {8'h00, 1'b0, 1'b1, malformed};
                pending_words.push_back(w);
                clear();
            end
        endfunction

        task report(string msg);
            $display("MISMATCH: %s", msg);
            errors++;
        endtask

        task check_word(word_t got);
            word_t want;
            if (pending_words.size() == 0)
            begin
                report($sformatf("unexpected word out_byte=%h has=%b eos=%b bad=%b",
                                 got.data, got.has, got.eos, got.bad));
                return;
            end
            want = pending_words.pop_front();
            if (got.data !== want.data)
                report($sformatf("out_byte %h, want %h", got.data, want.data));
            if (got.has !== want.has)
                report($sformatf("has_byte %b, want %b", got.has, want.has));
            if (got.eos !== want.eos)
                report($sformatf("end_of_string %b, want %b", got.eos, want.eos));
            if (got.bad !== want.bad)
                report($sformatf("bad_string %b, want %b", got.bad, want.bad));
        endtask
    endclass

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_stall;
    logic [7:0] in_byte;
    logic       last;
    logic       out_valid;
    logic       out_stall;
    logic [7:0] out_byte;
    logic       has_byte;
    logic       end_of_string;
    logic       bad_string;

    logic       quiet = 1'b0;
    int         cycles = 0;
    int         items_sent = 0;
    logic [7:0] body[$];
    unescape_predictor unescaper = new();

    json_string_unescape_utf8_core DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .in_byte       (in_byte),
        .last          (last),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .out_byte      (out_byte),
        .has_byte      (has_byte),
        .end_of_string (end_of_string),
        .bad_string    (bad_string)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("DONE: errors detected");
        $finish;
    end

    function int pick_gap();
        return quiet ? 0 : $urandom_range(0, 8);
    endfunction

    function logic [7:0] hex_char(logic [3:0] n);
        if (n < 4'd10) return 8'h30 + 8'(n);
        return (($urandom_range(0, 1) != 0) ? 8'h41 : 8'h61) + 8'(n) - 8'd10;
    endfunction

    function logic [7:0] non_hex();
        logic [7:0] c;
        do c = 8'($urandom); while (unescaper.nibble(c) >= 0);
        return c;
    endfunction

    function void put_text(string s);
        foreach (s[i]) body.push_back(s[i]);
    endfunction

    function void put_quad(logic [15:0] v);
        body.push_back(hex_char(v[15:12]));
        body.push_back(hex_char(v[11:8]));
        body.push_back(hex_char(v[7:4]));
        body.push_back(hex_char(v[3:0]));
    endfunction

    function logic [9:0] surr_offset();
        case ($urandom_range(0, 5))
            0: return 10'h000;
            1: return 10'h3FF;
            default: return 10'($urandom);
        endcase
    endfunction

    function void add_simple();
        body.push_back(jsu8_pkg::CH_BSL);
        body.push_back(ESC_LETTERS[$urandom_range(0, 7)]);
    endfunction

    function void add_bmp();
        logic [15:0] cp;
        case ($urandom_range(0, 4))
            0: cp = 16'($urandom_range(0, 'h7F));
            1: cp = 16'($urandom_range('h80, 'h7FF));
            2: cp = 16'($urandom_range('h800, 'hD7FF));
            3: cp = 16'($urandom_range('hE000, 'hFFFF));
            default:
                case ($urandom_range(0, 7))
                    0: cp = 16'h0000;
                    1: cp = 16'h007F;
                    2: cp = 16'h0080;
                    3: cp = 16'h07FF;
                    4: cp = 16'h0800;
                    5: cp = 16'hD7FF;
                    6: cp = 16'hE000;
                    default: cp = 16'hFFFF;
                endcase
        endcase
        put_text("\\u");
        put_quad(cp);
    endfunction

    function void add_pair();
        put_text("\\u");
        put_quad(jsu8_pkg::HI_SURR_MIN + 16'(surr_offset()));
        put_text("\\u");
        put_quad(jsu8_pkg::LO_SURR_MIN + 16'(surr_offset()));
    endfunction

    function void add_fault();
        logic [7:0] c;
        logic [15:0] v;
        case ($urandom_range(0, 4))
            0: body.push_back(8'($urandom_range(0, 31)));
            1:
            begin
                // backslash followed by anything that is not an escape letter
                do c = 8'($urandom);
                while (c inside {jsu8_pkg::CH_QUOTE, jsu8_pkg::CH_BSL, jsu8_pkg::CH_SLASH,
                                 jsu8_pkg::CH_B, jsu8_pkg::CH_F, jsu8_pkg::CH_N,
                                 jsu8_pkg::CH_R, jsu8_pkg::CH_T, jsu8_pkg::CH_U});
                body.push_back(jsu8_pkg::CH_BSL);
                body.push_back(c);
            end
            2:
            begin
                put_text("\\u");
                repeat ($urandom_range(0, 3)) body.push_back(hex_char(4'($urandom)));
                body.push_back(non_hex());
            end
            3:
            begin
                put_text("\\u");
                put_quad(jsu8_pkg::LO_SURR_MIN + 16'(surr_offset()));
            end
            default:
            begin
                // high surrogate, then a broken second half
                put_text("\\u");
                put_quad(jsu8_pkg::HI_SURR_MIN + 16'(surr_offset()));
                case ($urandom_range(0, 3))
                    0:
                    begin
                        do c = 8'($urandom); while (c == jsu8_pkg::CH_BSL);
                        body.push_back(c);
                    end
                    1:
                    begin
                        do c = 8'($urandom); while (c == jsu8_pkg::CH_U);
                        body.push_back(jsu8_pkg::CH_BSL);
                        body.push_back(c);
                    end
                    2:
                    begin
                        do v = 16'($urandom);
                        while (v >= jsu8_pkg::LO_SURR_MIN && v <= jsu8_pkg::LO_SURR_MAX);
                        put_text("\\u");
                        put_quad(v);
                    end
                    default:
                    begin
                        put_text("\\u");
                        repeat ($urandom_range(0, 3)) body.push_back(hex_char(4'($urandom)));
                        body.push_back(non_hex());
                    end
                endcase
            end
        endcase
    endfunction

    // a valid escape with its tail chopped off; the string ends right after it
    function void add_cut();
        int base;
        int keep;
        base = body.size();
        case ($urandom_range(0, 2))
            0: add_simple();
            1: add_bmp();
            default: add_pair();
        endcase
        keep = $urandom_range(1, body.size() - base - 1);
        while (body.size() > base + keep) void'(body.pop_back());
    endfunction

    function void build_string();
        int segs;
        int r;
        logic [7:0] c;
        body.delete();
        segs = $urandom_range(1, 6);
        for (int i = 0; i < segs; i++)
        begin
            r = $urandom_range(0, 99);
            if (r < 35)
            begin
                do c = 8'($urandom_range(32, 255)); while (c == jsu8_pkg::CH_BSL);
                body.push_back(c);
            end
            else if (r < 55) add_simple();
            else if (r < 73) add_bmp();
            else if (r < 85) add_pair();
            else if (r < 92) add_fault();
            else if (r < 96) body.push_back(8'($urandom));
            else
            begin
                add_cut();
                break;
            end
        end
    endfunction

    task send_word(logic [7:0] b, logic fin);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_byte  <= b;
        last     <= fin;
        do @(posedge clk); while (in_stall !== 1'b0);
        unescaper.take_input(b, fin);
        items_sent++;
    endtask

    task send_string();
        for (int i = 0; i < body.size(); i++) send_word(body[i], i == body.size() - 1);
    endtask

    task drain_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (unescaper.pending() != 0) @(posedge clk);
    endtask

    // result side
    initial
    begin
        word_t got;
        int gap;
        out_stall <= 1'b0;
        @(posedge clk);
        forever
        begin
            gap = pick_gap();
            if (gap > 0)
            begin
                out_stall <= 1'b1;
                repeat (gap) @(posedge clk);
            end
            out_stall <= 1'b0;
            do @(posedge clk); while (out_valid !== 1'b1);
            got = {out_byte, has_byte, end_of_string, bad_string};
            unescaper.check_word(got);
        end
    end

    initial
    begin
        rst_n    <= 1'b0;
        in_valid <= 1'b0;
        in_byte  <= 8'h00;
        last     <= 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // top byte, space, surrogate pair into four bytes
        body.delete();
        body.push_back(8'hFF);
        put_text(" \\uD83D\\uDE00");
        send_string();
        // control byte alone
        body.delete();
        body.push_back(8'h00);
        send_string();
        // unknown escape, trailing byte ignored
        body.delete();
        put_text("\\qx");
        send_string();
        // lone low surrogate
        body.delete();
        put_text("\\udc00");
        send_string();
        // string ends on a bare backslash
        body.delete();
        put_text("\\");
        send_string();

        drain_results();

        items_sent = 0;
        while (items_sent < RANDOM_ITEMS)
        begin
            if ($urandom_range(0, 9) == 0) quiet = ~quiet;
            if ($urandom_range(0, 19) == 0) drain_results();
            build_string();
            send_string();
        end

        in_valid <= 1'b0;
        do @(posedge clk); while (unescaper.pending() != 0);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (unescaper.errors == 0 && unescaper.pending() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
